// ===== hw/rtl/olist_pkg.sv =====
// Shared types and constants for the ordered list engine.
package olist_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int KIND_W        = 3;
   localparam int VALUE_W       = 32;
   localparam int POS_W         = 8;
   localparam int STATUS_W      = 2;
   localparam int COUNT_OUT_W   = 5;

   typedef enum logic [KIND_W-1:0] {
      KIND_APPEND = 3'd0,
      KIND_DELETE = 3'd1,
      KIND_FIND   = 3'd2,
      KIND_READ   = 3'd3,
      KIND_CLEAR  = 3'd4
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_MOD,
      S_EXEC,
      S_SCAN,
      S_RESULT
   } state_type;

   // Per-cycle command broadcast to every cell.
   typedef struct packed {
      logic append;
      logic remove;
      logic find;
      logic read;
   } cmd_type;

endpackage

// ===== hw/rtl/olist_if.sv =====
// Request and response channel interfaces of the ordered list engine.
interface olist_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [olist_pkg::KIND_W-1:0]         kind;
   logic signed [olist_pkg::VALUE_W-1:0] value;
   logic [olist_pkg::POS_W-1:0]          position;

   modport source (output valid, kind, value, position, input ready);
   modport sink (input valid, kind, value, position, output ready);
endinterface

interface olist_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [olist_pkg::VALUE_W-1:0]   read_value;
   logic                                   found;
   logic [olist_pkg::STATUS_W-1:0]         status;
   logic [olist_pkg::COUNT_OUT_W-1:0]      entry_count;

   modport source (output valid, read_value, found, status, entry_count, input ready);
   modport sink (input valid, read_value, found, status, entry_count, output ready);
endinterface

// ===== hw/rtl/olist_cell.sv =====
// One list cell: holds one entry, shifts on delete, folds its match and its read value into the scan chain.
module olist_cell #(
   parameter int DEPTH = olist_pkg::DEPTH_DEFAULT,
   parameter int INDEX = 0
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  olist_pkg::cmd_type                   cmd,
   input  logic signed [olist_pkg::VALUE_W-1:0] key,
   input  logic [$clog2(DEPTH+1)-1:0]           count,
   input  logic [$clog2(DEPTH+1)-1:0]           sel,
   input  logic signed [olist_pkg::VALUE_W-1:0] next_value,
   input  logic                                 hit_in,
   input  logic signed [olist_pkg::VALUE_W-1:0] data_in,
   output logic signed [olist_pkg::VALUE_W-1:0] value_out,
   output logic                                 hit_out,
   output logic signed [olist_pkg::VALUE_W-1:0] data_out
);

   localparam int CW = $clog2(DEPTH+1);
   localparam logic [CW-1:0] MY_INDEX = CW'(INDEX);

   logic signed [olist_pkg::VALUE_W-1:0] value_ff, value_in;
   logic                                 hit_ff, hit_in_local;
   logic signed [olist_pkg::VALUE_W-1:0] data_ff, data_in_local;
   logic                                 in_range;

   assign in_range = MY_INDEX < count;

   always_comb begin
      value_in = value_ff;
      if (cmd.append && (count == MY_INDEX)) begin
         value_in = key;
      end else if (cmd.remove && (MY_INDEX >= sel)) begin
         value_in = next_value;
      end
   end

   always_comb begin
      hit_in_local  = hit_in | (cmd.find & in_range & (value_ff == key));
      data_in_local = data_in;
      if (cmd.read && in_range && (MY_INDEX == sel)) begin
         data_in_local = data_in | value_ff;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      data_ff  <= data_in_local;
      if (reset) begin
         hit_ff <= 1'b0;
      end else begin
         hit_ff <= hit_in_local;
      end
   end

   assign value_out = value_ff;
   assign hit_out   = hit_ff;
   assign data_out  = data_ff;

endmodule

// ===== hw/rtl/olist_mod.sv =====
// Bit-serial remainder unit: position modulo entry count, one dividend bit per cycle.
module olist_mod #(
   parameter int DEPTH = olist_pkg::DEPTH_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [olist_pkg::POS_W-1:0]        dividend,
   input  logic [$clog2(DEPTH+1)-1:0]         divisor,
   output logic                               done,
   output logic [$clog2(DEPTH+1)-1:0]         remainder
);

   localparam int CW     = $clog2(DEPTH+1);
   localparam int STEP_W = $clog2(olist_pkg::POS_W);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(olist_pkg::POS_W - 1);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [STEP_W-1:0]             step_ff, step_in;
   logic [olist_pkg::POS_W-1:0]   div_ff, div_in;
   logic [CW-1:0]                 rem_ff, rem_in;
   logic [CW:0]                   trial;

   assign trial = {rem_ff, div_ff[olist_pkg::POS_W-1]};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      div_in  = div_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         div_in  = dividend;
         rem_in  = '0;
      end else if (busy_ff) begin
         // remainder stays below divisor, so the trial fits in CW+1 bits
         if (trial >= {1'b0, divisor}) begin
            rem_in = CW'(trial - {1'b0, divisor});
         end else begin
            rem_in = trial[CW-1:0];
         end
         div_in  = div_ff << 1;
         step_in = step_ff + STEP_W'(1);
         if (step_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      div_ff  <= div_in;
      rem_ff  <= rem_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

// ===== hw/rtl/ordered_list_engine.sv =====
// Top level of the ordered list engine: sequencer, cell chain and remainder unit.
//
//   channel    dir   transfer carries
//   req_chan   in    kind, value, position
//   rsp_chan   out   read_value, found, status, entry_count
//
// Append, clear, unused kinds and empty ops go from request transfer through S_EXEC and S_RESULT to response valid.
// Delete and read first run the bit-serial remainder unit in S_MOD (8 steps, then the done handoff).
// Find and read then walk the whole cell chain in S_SCAN, one cell per cycle.
// A held response does not block the next request transfer; the sequencer waits
// only when a new result is ready and the old one is still pending.
// Synchronous reset empties the list; entry storage itself is not cleared.
module ordered_list_engine #(
   parameter int DEPTH = olist_pkg::DEPTH_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   olist_req_if.sink    req_chan,
   olist_rsp_if.source  rsp_chan
);

   localparam int CW = $clog2(DEPTH+1);
   localparam int SW = $clog2(DEPTH);
   localparam logic [CW-1:0] DEPTH_C   = CW'(DEPTH);
   localparam logic [SW-1:0] LAST_SCAN = SW'(DEPTH - 1);

   olist_pkg::state_type  state_ff, state_in;
   olist_pkg::kind_type   op_ff, op_in;
   olist_pkg::status_type status_ff, status_in;
   logic signed [olist_pkg::VALUE_W-1:0] key_ff, key_in;
   logic [olist_pkg::POS_W-1:0]          pos_ff, pos_in;
   logic [CW-1:0]                        sel_ff, sel_in;
   logic [CW-1:0]                        count_ff, count_in;
   logic [SW-1:0]                        scan_ff, scan_in;

   logic                                 rsp_valid_ff, rsp_valid_in;
   logic signed [olist_pkg::VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   logic                                 rsp_found_ff, rsp_found_in;
   logic [olist_pkg::STATUS_W-1:0]       rsp_status_ff, rsp_status_in;
   logic [olist_pkg::COUNT_OUT_W-1:0]    rsp_count_ff, rsp_count_in;

   olist_pkg::cmd_type cmd;
   olist_pkg::kind_type req_kind;
   logic               req_xfer;
   logic               needs_mod;
   logic               mod_start;
   logic               mod_done;
   logic [CW-1:0]      mod_rem;
   logic               rsp_free;
   logic               rsp_load;
   logic               list_empty;

   logic signed [olist_pkg::VALUE_W-1:0] cell_value [DEPTH];
   logic signed [olist_pkg::VALUE_W-1:0] next_value [DEPTH];
   logic                                 acc_hit  [DEPTH+1];
   logic signed [olist_pkg::VALUE_W-1:0] acc_data [DEPTH+1];

   assign req_kind   = olist_pkg::kind_type'(req_chan.kind);
   assign req_xfer   = req_chan.valid && req_chan.ready;
   assign list_empty = (count_ff == '0);
   assign needs_mod  = ((req_kind == olist_pkg::KIND_DELETE) ||
                        (req_kind == olist_pkg::KIND_READ)) && !list_empty;
   assign rsp_free   = !rsp_valid_ff || rsp_chan.ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         olist_pkg::S_IDLE: begin
            if (req_xfer) begin
               state_in = needs_mod ? olist_pkg::S_MOD : olist_pkg::S_EXEC;
            end
         end
         olist_pkg::S_MOD: begin
            if (mod_done) begin
               state_in = olist_pkg::S_EXEC;
            end
         end
         olist_pkg::S_EXEC: begin
            if (((op_ff == olist_pkg::KIND_FIND) || (op_ff == olist_pkg::KIND_READ)) &&
                !list_empty) begin
               state_in = olist_pkg::S_SCAN;
            end else begin
               state_in = olist_pkg::S_RESULT;
            end
         end
         olist_pkg::S_SCAN: begin
            if (scan_ff == LAST_SCAN) begin
               state_in = olist_pkg::S_RESULT;
            end
         end
         olist_pkg::S_RESULT: begin
            if (rsp_free) begin
               state_in = olist_pkg::S_IDLE;
            end
         end
         default: state_in = olist_pkg::S_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_chan.ready = 1'b0;
      mod_start      = 1'b0;
      rsp_load       = 1'b0;
      cmd            = '0;
      // find/read flags hold through the walk; cells never change under them
      cmd.find       = (op_ff == olist_pkg::KIND_FIND);
      cmd.read       = (op_ff == olist_pkg::KIND_READ);
      case (state_ff)
         olist_pkg::S_IDLE: begin
            req_chan.ready = 1'b1;
            mod_start      = req_chan.valid && needs_mod;
         end
         olist_pkg::S_EXEC: begin
            cmd.append = (op_ff == olist_pkg::KIND_APPEND) && (count_ff < DEPTH_C);
            cmd.remove = (op_ff == olist_pkg::KIND_DELETE) && !list_empty;
         end
         olist_pkg::S_RESULT: begin
            rsp_load = rsp_free;
         end
         default: begin
         end
      endcase
   end

   // datapath registers
   always_comb begin
      op_in     = op_ff;
      key_in    = key_ff;
      pos_in    = pos_ff;
      sel_in    = sel_ff;
      count_in  = count_ff;
      status_in = status_ff;
      scan_in   = scan_ff;
      case (state_ff)
         olist_pkg::S_IDLE: begin
            if (req_xfer) begin
               op_in     = req_kind;
               key_in    = req_chan.value;
               pos_in    = req_chan.position;
               status_in = olist_pkg::ST_OK;
            end
         end
         olist_pkg::S_MOD: begin
            if (mod_done) begin
               sel_in = mod_rem;
            end
         end
         olist_pkg::S_EXEC: begin
            scan_in = '0;
            case (op_ff)
               olist_pkg::KIND_APPEND: begin
                  if (count_ff < DEPTH_C) begin
                     count_in = count_ff + CW'(1);
                  end else begin
                     status_in = olist_pkg::ST_FULL;
                  end
               end
               olist_pkg::KIND_DELETE: begin
                  if (list_empty) begin
                     status_in = olist_pkg::ST_EMPTY;
                  end else begin
                     count_in = count_ff - CW'(1);
                  end
               end
               olist_pkg::KIND_READ: begin
                  if (list_empty) begin
                     status_in = olist_pkg::ST_EMPTY;
                  end
               end
               olist_pkg::KIND_CLEAR: begin
                  count_in = '0;
               end
               default: begin
               end
            endcase
         end
         olist_pkg::S_SCAN: begin
            scan_in = scan_ff + SW'(1);
         end
         default: begin
         end
      endcase
   end

   // response register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_value_in  = rsp_value_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      if (rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_value_in  = ((op_ff == olist_pkg::KIND_READ) && !list_empty) ?
                         acc_data[DEPTH] : '0;
         rsp_found_in  = (op_ff == olist_pkg::KIND_FIND) && !list_empty && acc_hit[DEPTH];
         rsp_status_in = status_ff;
         rsp_count_in  = olist_pkg::COUNT_OUT_W'(count_ff);
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      key_ff        <= key_in;
      pos_ff        <= pos_in;
      sel_ff        <= sel_in;
      status_ff     <= status_in;
      scan_ff       <= scan_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
      if (reset) begin
         state_ff     <= olist_pkg::S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.read_value  = rsp_value_ff;
   assign rsp_chan.found       = rsp_found_ff;
   assign rsp_chan.status      = rsp_status_ff;
   assign rsp_chan.entry_count = rsp_count_ff;

   olist_mod #(
      .DEPTH (DEPTH)
   ) u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (mod_start ? req_chan.position : pos_ff),
      .divisor   (count_ff),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   assign acc_hit[0]  = 1'b0;
   assign acc_data[0] = '0;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      if (i == DEPTH - 1) begin : g_tail
         assign next_value[i] = cell_value[i];
      end else begin : g_body
         assign next_value[i] = cell_value[i+1];
      end

      olist_cell #(
         .DEPTH (DEPTH),
         .INDEX (i)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .key        (key_ff),
         .count      (count_ff),
         .sel        (sel_ff),
         .next_value (next_value[i]),
         .hit_in     (acc_hit[i]),
         .data_in    (acc_data[i]),
         .value_out  (cell_value[i]),
         .hit_out    (acc_hit[i+1]),
         .data_out   (acc_data[i+1])
      );
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_C)
      else $error("entry count above depth");

   a_append_grows: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && (req_kind == olist_pkg::KIND_APPEND) && (count_ff < DEPTH_C))
      |=> ##1 (count_ff == $past(count_ff, 2) + CW'(1)))
      else $error("append did not grow the list");

   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == olist_pkg::S_MOD) && mod_done |-> (mod_rem < count_ff))
      else $error("wrapped position not below count");

   a_scan_op: assert property (@(posedge clock) disable iff (reset)
      (state_ff == olist_pkg::S_SCAN) |->
      ((op_ff == olist_pkg::KIND_FIND) || (op_ff == olist_pkg::KIND_READ)) && !list_empty)
      else $error("chain walk for an op that needs none");
`endif

endmodule
